/* hw/rtl/fbpa_pkg.sv */
// fbpa_pkg: types and codes of the fixed block pool allocator
// no dependencies; imported by fixed_block_pool_allocator
package fbpa_pkg;

	typedef enum logic [2:0] {
		ST_ALLOCATED = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_FREED     = 3'd3,
		ST_BAD_INDEX = 3'd4
	} status_t;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_WORK = 1'b1
	} fsm_state_t;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ADDR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE  = 2'd2;

	localparam int SIZE_W = 17;
	localparam int ADDR_W = 32;
	localparam int POOL_W = 11;
	localparam int ALIGN_W = 4;
	localparam int BLK_W = 10;

endpackage

/* hw/rtl/fbpa_ram.sv */
// fbpa_ram: generic single-write, single-read ram with registered read data
// no dependencies; holds the free-list links of the allocator
module fbpa_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/fixed_block_pool_allocator.sv */
// fixed_block_pool_allocator: fixed-size block pool with a lifo free list
// depends on fbpa_pkg and fbpa_ram (free-list link memory)
// the taken input word is registered in stage 1, then in the result register once the output is free
// one word in flight: no new word is taken until the last one is loaded into the result register
// reset: arst_n resets control, configuration and pool state at once; a config write
// to a known index empties the pool; the link memory is never cleared
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0]     cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic [fbpa_pkg::SIZE_W-1:0]     request_size,
	input  logic [fbpa_pkg::ALIGN_W-1:0]    alignment_log2,
	input  logic [fbpa_pkg::BLK_W-1:0]      block_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output fbpa_pkg::status_t               status,
	output logic [fbpa_pkg::BLK_W-1:0]      granted_index,
	output logic [fbpa_pkg::ADDR_W-1:0]     granted_address,
	output logic [fbpa_pkg::POOL_W-1:0]     blocks_allocated
);

	import fbpa_pkg::*;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int N_W    = (CNT_W > POOL_W) ? CNT_W : POOL_W;
	localparam int IW     = (IDX_W > BLK_W) ? IDX_W : BLK_W;
	localparam int PROD_W = IDX_W + SIZE_W;
	localparam int PW     = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

	// configuration
	logic [SIZE_W-1:0] block_size_q;
	logic [ADDR_W-1:0] base_q;
	logic [POOL_W-1:0] pool_q;

	// pool state
	logic [IDX_W-1:0] head_q;
	logic             head_valid_q;
	logic [CNT_W-1:0] wm_q;
	logic [CNT_W-1:0] count_q;

	fsm_state_t state_q, state_d;
	logic       accept, out_load, ram_re, ram_we;

	// decision logic
	logic [N_W-1:0]    pool_ext, n_blocks, wm_ext, cnt_ext, blk_ext;
	logic              too_large, empty, bad, grant, push;
	logic [IDX_W-1:0]  grant_idx;
	logic [CNT_W-1:0]  count_d;
	status_t           status_d;
	logic [PROD_W-1:0] prod_d;

	// stage 1
	status_t           status_s1;
	logic              ok_s1, pop_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [ALIGN_W-1:0] align_s1;
	logic [CNT_W-1:0]  count_s1;

	// link memory
	logic [IDX_W:0] ram_rdata;

	// address stage
	logic [PW-1:0]     prod_ext;
	logic [ADDR_W-1:0] mask, aligned;
	logic [IW-1:0]     idx_ext;
	logic [N_W-1:0]    count_out_ext;

	// result register
	logic              out_valid_q;
	status_t           status_q;
	logic [BLK_W-1:0]  granted_index_q;
	logic [ADDR_W-1:0] granted_address_q;
	logic [POOL_W-1:0] blocks_allocated_q;

	assign accept = in_valid && in_ready;

	always_comb begin
		pool_ext = N_W'(pool_q);
		n_blocks = (pool_ext > N_W'(MAX_BLOCKS)) ? N_W'(MAX_BLOCKS) : pool_ext;
		wm_ext   = N_W'(wm_q);
		cnt_ext  = N_W'(count_q);
		blk_ext  = N_W'(block_index);

		too_large = request_size > block_size_q;
		empty     = (cnt_ext >= n_blocks) || (!head_valid_q && (wm_ext >= n_blocks));
		bad       = (blk_ext >= n_blocks) || (blk_ext >= wm_ext);
		grant     = (action == ACT_ALLOC) && !too_large && !empty;
		push      = (action == ACT_FREE) && !bad;

		grant_idx = head_valid_q ? head_q : wm_q[IDX_W-1:0];
		prod_d    = PROD_W'(grant_idx) * PROD_W'(block_size_q);

		count_d = count_q;
		if (grant) begin
			count_d = count_q + CNT_W'(1);
		end else if (push && (count_q != '0)) begin
			count_d = count_q - CNT_W'(1);
		end

		if (action == ACT_ALLOC) begin
			if (too_large) begin
				status_d = ST_TOO_LARGE;
			end else if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				status_d = ST_ALLOCATED;
			end
		end else begin
			status_d = bad ? ST_BAD_INDEX : ST_FREED;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_WORK;
				end
			end
			S_WORK: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_WORK: out_load = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ram_re = accept && grant && head_valid_q;
	assign ram_we = accept && push;

	fbpa_ram #(
		.WIDTH (IDX_W + 1),
		.DEPTH (MAX_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (blk_ext[IDX_W-1:0]),
		.wdata ({head_valid_q, head_q}),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// configuration and pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= SIZE_W'(64);
			base_q       <= '0;
			pool_q       <= POOL_W'(1024);
			head_q       <= '0;
			head_valid_q <= 1'b0;
			wm_q         <= '0;
			count_q      <= '0;
		end else if (cfg_we && ((cfg_index == CFG_BLOCK_SIZE) ||
				(cfg_index == CFG_FIRST_ADDR) || (cfg_index == CFG_POOL_SIZE))) begin
			case (cfg_index)
				CFG_BLOCK_SIZE: block_size_q <= cfg_wdata[SIZE_W-1:0];
				CFG_FIRST_ADDR: base_q       <= cfg_wdata;
				CFG_POOL_SIZE:  pool_q       <= cfg_wdata[POOL_W-1:0];
				default:        base_q       <= base_q;
			endcase
			head_q       <= '0;
			head_valid_q <= 1'b0;
			wm_q         <= '0;
			count_q      <= '0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				if (grant && !head_valid_q) begin
					wm_q <= wm_q + CNT_W'(1);
				end
				if (push) begin
					head_q       <= blk_ext[IDX_W-1:0];
					head_valid_q <= 1'b1;
				end
			end
			if (out_load && pop_s1) begin
				head_q       <= ram_rdata[IDX_W-1:0];
				head_valid_q <= ram_rdata[IDX_W];
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_s1 <= 1'b0;
		end else if (accept) begin
			pop_s1 <= grant && head_valid_q;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			ok_s1     <= grant;
			idx_s1    <= grant_idx;
			prod_s1   <= prod_d;
			align_s1  <= alignment_log2;
			count_s1  <= count_d;
		end
	end

	// address rounding
	always_comb begin
		prod_ext      = PW'(prod_s1);
		mask          = ~({ADDR_W{1'b1}} << align_s1);
		aligned       = (base_q + prod_ext[ADDR_W-1:0] + mask) & ~mask;
		idx_ext       = IW'(idx_s1);
		count_out_ext = N_W'(count_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q           <= status_s1;
			granted_index_q    <= ok_s1 ? idx_ext[BLK_W-1:0] : '0;
			granted_address_q  <= ok_s1 ? aligned : '0;
			blocks_allocated_q <= count_out_ext[POOL_W-1:0];
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign granted_index    = granted_index_q;
	assign granted_address  = granted_address_q;
	assign blocks_allocated = blocks_allocated_q;

`ifndef SYNTH
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("link memory read and write in one cycle");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> head_valid_q)
		else $error("pop issued with empty free list");

	a_wm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		N_W'(wm_q) <= N_W'(MAX_BLOCKS))
		else $error("watermark beyond pool maximum");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second word taken while one is in flight");

	a_pop_head_update: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && pop_s1) |=> (head_q == $past(ram_rdata[IDX_W-1:0])))
		else $error("free-list head not taken from link memory");
`endif

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for fixed_block_pool_allocator, directed words then random phases
// depends on fbpa_pkg and the fixed_block_pool_allocator rtl; an in-bench pool model predicts results
module tb_top;
	import fbpa_pkg::*;

	localparam int POOL_MAX = 1024;
	localparam int WORD_TARGET = 1150;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct {
		action_t                act;
		logic [SIZE_W-1:0]      size;
		logic [ALIGN_W-1:0]     align;
		logic [BLK_W-1:0]       blk;
	} pool_word_t;

	typedef struct {
		status_t                status;
		logic [BLK_W-1:0]       grant_idx;
		logic [ADDR_W-1:0]      grant_addr;
		logic [POOL_W-1:0]      in_use;
	} grant_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_BLOCK_SIZE;
	logic [ADDR_W-1:0]      cfg_wdata = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   action = ACT_ALLOC;
	logic [SIZE_W-1:0]      request_size = '0;
	logic [ALIGN_W-1:0]     alignment_log2 = '0;
	logic [BLK_W-1:0]       block_index = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	status_t                status;
	logic [BLK_W-1:0]       granted_index;
	logic [ADDR_W-1:0]      granted_address;
	logic [POOL_W-1:0]      blocks_allocated;

	fixed_block_pool_allocator i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.request_size    (request_size),
		.alignment_log2  (alignment_log2),
		.block_index     (block_index),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.granted_index   (granted_index),
		.granted_address (granted_address),
		.blocks_allocated(blocks_allocated)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// pool model state
	logic [SIZE_W-1:0]      cfg_block_size = 17'd64;
	logic [ADDR_W-1:0]      cfg_first_addr = '0;
	logic [POOL_W-1:0]      cfg_pool_blocks = 11'd1024;
	logic [BLK_W-1:0]       link_mem [POOL_MAX];
	bit                     link_ok [POOL_MAX];
	logic [BLK_W-1:0]       free_head = '0;
	bit                     head_ok = 1'b0;
	logic [POOL_W-1:0]      watermark = '0;
	logic [POOL_W-1:0]      alloc_cnt = '0;
	int                     held[$];
	int                     free_cands[$];

	pool_word_t             request_q[$];
	grant_t                 expected_grants[$];
	int                     words_queued = 0;
	int                     words_taken = 0;
	int                     failures = 0;
	int                     cycle_cnt = 0;

	function automatic void clear_pool_state();
		for (int k = 0; k < POOL_MAX; k++) begin
			link_ok[k] = 1'b0;
		end
		free_head = '0;
		head_ok = 1'b0;
		watermark = '0;
		alloc_cnt = '0;
		held.delete();
	endfunction

	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
		case (idx)
			CFG_BLOCK_SIZE: cfg_block_size = data[SIZE_W-1:0];
			CFG_FIRST_ADDR: cfg_first_addr = data;
			CFG_POOL_SIZE:  cfg_pool_blocks = data[POOL_W-1:0];
			default: return;
		endcase
		clear_pool_state();
	endfunction

	function automatic grant_t pool_step(pool_word_t w);
		grant_t r;
		logic [POOL_W-1:0] usable;
		logic [BLK_W-1:0] slot;
		logic [63:0] mask;
		logic [63:0] addr;
		r.status = ST_ALLOCATED;
		r.grant_idx = '0;
		r.grant_addr = '0;
		usable = (cfg_pool_blocks > POOL_MAX) ? POOL_W'(POOL_MAX) : cfg_pool_blocks;
		if (w.act == ACT_ALLOC) begin
			if (w.size > cfg_block_size) begin
				r.status = ST_TOO_LARGE;
			end else if (alloc_cnt >= usable || (!head_ok && watermark >= usable)) begin
				r.status = ST_EMPTY;
			end else begin
				if (head_ok) begin
					slot = free_head;
					head_ok = link_ok[slot];
					free_head = link_mem[slot];
				end else begin
					slot = watermark[BLK_W-1:0];
					watermark = watermark + 1'b1;
				end
				alloc_cnt = alloc_cnt + 1'b1;
				mask = (64'd1 << w.align) - 64'd1;
				addr = 64'(cfg_first_addr) + 64'(slot) * 64'(cfg_block_size);
				addr = (addr + mask) & ~mask;
				r.grant_idx = slot;
				r.grant_addr = addr[ADDR_W-1:0];
				held.push_back(int'(slot));
			end
		end else begin
			if (w.blk >= usable || w.blk >= watermark) begin
				r.status = ST_BAD_INDEX;
			end else begin
				link_mem[w.blk] = free_head;
				link_ok[w.blk] = head_ok;
				free_head = w.blk;
				head_ok = 1'b1;
				if (alloc_cnt > 0) begin
					alloc_cnt = alloc_cnt - 1'b1;
				end
				r.status = ST_FREED;
				for (int k = 0; k < held.size(); k++) begin
					if (held[k] == int'(w.blk)) begin
						held.delete(k);
						break;
					end
				end
			end
		end
		r.in_use = alloc_cnt;
		return r;
	endfunction

	function automatic void queue_word(action_t act, int size, int align, int blk);
		pool_word_t w;
		w.act = act;
		w.size = SIZE_W'(size);
		w.align = ALIGN_W'(align);
		w.blk = BLK_W'(blk);
		request_q.push_back(w);
		words_queued++;
	endfunction

	// mostly frees of blocks really out on loan, some double and stray frees
	function automatic pool_word_t make_word(int alloc_pct);
		pool_word_t w;
		int pick;
		int pos;
		w.act = ($urandom_range(1, 100) <= alloc_pct) ? ACT_ALLOC : ACT_FREE;
		w.size = SIZE_W'($urandom);
		w.align = ALIGN_W'($urandom);
		w.blk = BLK_W'($urandom);
		if (w.act == ACT_ALLOC) begin
			case ($urandom_range(0, 9))
				0: w.size = cfg_block_size;
				1: w.size = cfg_block_size + 1'b1;
				2: ;
				default: w.size = SIZE_W'($urandom_range(0, cfg_block_size));
			endcase
			if ($urandom_range(0, 7) != 0) begin
				w.align = ALIGN_W'($urandom_range(1, 12));
			end
		end else begin
			pick = $urandom_range(0, 19);
			if (pick < 14 && free_cands.size() > 0) begin
				pos = $urandom_range(0, free_cands.size() - 1);
				w.blk = BLK_W'(free_cands[pos]);
				free_cands.delete(pos);
			end else if (pick < 17) begin
				w.blk = BLK_W'($urandom_range(0, watermark));
			end
		end
		return w;
	endfunction

	task automatic drain();
		while (words_taken != words_queued || expected_grants.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		apply_reg_write(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_pool(int bsize, logic [ADDR_W-1:0] first, int blocks);
		int start;
		drain();
		start = $urandom_range(0, 2);
		for (int k = 0; k < 3; k++) begin
			case ((start + k) % 3)
				0: write_reg(CFG_BLOCK_SIZE, ADDR_W'(bsize));
				1: write_reg(CFG_FIRST_ADDR, first);
				default: write_reg(CFG_POOL_SIZE, ADDR_W'(blocks));
			endcase
		end
	endtask

	// chunks are built once the previous one is taken, so the model state is current
	task automatic run_phase(int n_words, int alloc_pct);
		int left;
		int chunk;
		left = n_words;
		while (left > 0) begin
			do @(negedge clk); while (words_taken != words_queued);
			free_cands = held;
			chunk = $urandom_range(1, 32);
			if (chunk > left) begin
				chunk = left;
			end
			repeat (chunk) request_q.push_back(make_word(alloc_pct));
			words_queued += chunk;
			left -= chunk;
		end
	endtask

	// sender: bursts and gaps
	pool_word_t on_port;
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_ALLOC;
			request_size <= '0;
			alignment_log2 <= '0;
			block_index <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_grants.push_back(pool_step(on_port));
				words_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (request_q.size() > 0) begin
					on_port = request_q.pop_front();
					action <= on_port.act;
					request_size <= on_port.size;
					alignment_log2 <= on_port.align;
					block_index <= on_port.blk;
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern changes every so often
	int stall_mode = 0;
	int mode_left = 0;
	grant_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_grants.size() == 0) begin
					$error("result word with nothing expected");
					failures++;
				end else begin
					want = expected_grants.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						failures++;
					end
					if (granted_index !== want.grant_idx) begin
						$error("granted_index: expected %0d, got %0d",
							want.grant_idx, granted_index);
						failures++;
					end
					if (granted_address !== want.grant_addr) begin
						$error("granted_address: expected %h, got %h",
							want.grant_addr, granted_address);
						failures++;
					end
					if (blocks_allocated !== want.in_use) begin
						$error("blocks_allocated: expected %0d, got %0d",
							want.in_use, blocks_allocated);
						failures++;
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 160);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ~out_ready;
				default: out_ready <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("fixed_block_pool_allocator verification failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: 64-byte blocks from address 0, 1024 blocks
		queue_word(ACT_FREE, 0, 1, 5);
		queue_word(ACT_ALLOC, 0, 0, 0);
		queue_word(ACT_ALLOC, 64, 15, 0);
		queue_word(ACT_ALLOC, 65, 1, 0);
		queue_word(ACT_ALLOC, 17'h1FFFF, 15, 0);
		queue_word(ACT_ALLOC, 1, 12, 0);
		queue_word(ACT_FREE, 0, 0, 1);
		queue_word(ACT_FREE, 0, 0, 1023);
		queue_word(ACT_FREE, 0, 0, 3);
		queue_word(ACT_FREE, 0, 0, 1);
		queue_word(ACT_ALLOC, 64, 6, 0);
		queue_word(ACT_ALLOC, 32, 3, 0);
		queue_word(ACT_FREE, 0, 0, 0);
		queue_word(ACT_FREE, 0, 0, 2);
		queue_word(ACT_ALLOC, 10, 4, 0);
		queue_word(ACT_ALLOC, 63, 8, 0);
		queue_word(ACT_FREE, 0, 0, 1);
		queue_word(ACT_FREE, 0, 0, 1);
		queue_word(ACT_FREE, 0, 0, 1);
		queue_word(ACT_FREE, 0, 0, 0);
		queue_word(ACT_ALLOC, 64, 9, 10'h3FF);
		queue_word(ACT_FREE, 17'h1FFFF, 4'hF, 2);

		set_pool(4, 32'hFFFF_FFFF, 1);
		run_phase(40, 55);
		set_pool(65536, 32'hFFFF_0000, 2047);
		run_phase(560, 93);
		set_pool(100, 32'h1234_5678, 0);
		run_phase(16, 50);

		while (words_queued < WORD_TARGET) begin
			set_pool(
				($urandom_range(0, 4) == 0) ? 4 :
				($urandom_range(0, 3) == 0) ? 65536 : $urandom_range(4, 65536),
				($urandom_range(0, 3) == 0) ? 32'h0 :
				($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom,
				($urandom_range(0, 19) == 0) ? 0 :
				($urandom_range(0, 5) == 0) ? $urandom_range(1025, 2047) :
				($urandom_range(0, 4) == 0) ? $urandom_range(25, 1024) :
				$urandom_range(1, 24));
			run_phase($urandom_range(30, 80), $urandom_range(40, 75));
		end

		drain();
		repeat (8) @(negedge clk);
		if (failures == 0) begin
			$display("fixed_block_pool_allocator verification clean");
		end else begin
			$display("fixed_block_pool_allocator verification failed");
		end
		$finish;
	end

endmodule
